// ----- design/spgt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared page group table package
// Request and status codes, size defaults and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spgt_pkg;

	localparam int DEF_GROUPS          = 64;
	localparam int DEF_PAGES_PER_GROUP = 128;

	localparam int ADDR_W  = 56;
	localparam int ID_W    = 16;
	localparam int REQ_W   = 3;
	localparam int STS_W   = 3;
	localparam int COUNT_W = 7;

	// Highest process count a group may hold.
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 7'd64;

	// Group id that stands for no group at all.
	localparam logic [ID_W-1:0] NO_GROUP = 16'hFFFF;

	localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_INC    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEC    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;

	localparam logic [STS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STS_W-1:0] ST_NOGROUP  = 3'd1;
	localparam logic [STS_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STS_W-1:0] ST_LIMIT    = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the accepted request
		logic lookup;  // compare the id against every slot
		logic select;  // pick the first matching or free slot
		logic fetch;   // read the slot's count and fill
		logic scan;    // one step of the page list scan
		logic commit;  // update the table and load the result register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

// ----- design/spgt_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid and ready handshake carrying one table request.
// ----------------------------------------------------------------------------
interface spgt_req_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  req_type;
	logic signed [15:0]          group_id;
	logic [55:0]                 phys_addr;

	modport source (output valid, output req_type, output group_id, output phys_addr,
		input ready);
	modport sink (input valid, input req_type, input group_id, input phys_addr,
		output ready);
endinterface

// ----- design/spgt_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid and ready handshake carrying the result of one table request.
// ----------------------------------------------------------------------------
interface spgt_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       is_member;
	logic       was_duplicate;
	logic [6:0] proc_count;

	modport source (output valid, output status, output is_member, output was_duplicate,
		output proc_count, input ready);
	modport sink (input valid, input status, input is_member, input was_duplicate,
		input proc_count, output ready);
endinterface

// ----- design/spgt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared page group table controller
// Steps each request through lookup, slot selection, fetch, scan and commit.
// ----------------------------------------------------------------------------
module spgt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spgt_pkg::dp_sts_t sts,
	output spgt_pkg::dp_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOOKUP = 6'b000010,
		S_SELECT = 6'b000100,
		S_FETCH  = 6'b001000,
		S_SCAN   = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = S_SELECT;
			end
			S_SELECT: begin
				cmd.select = 1'b1;
				state_d    = S_FETCH;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = sts.need_scan ? S_SCAN : S_FINISH;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// Wait here while the previous result has not been taken.
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/spgt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared page group table datapath
// Slot registers, count and fill memories, the page list memory, the scan
// unit and the result register.
// ----------------------------------------------------------------------------
module spgt_dp #(
	parameter int GROUPS          = spgt_pkg::DEF_GROUPS,
	parameter int PAGES_PER_GROUP = spgt_pkg::DEF_PAGES_PER_GROUP
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [spgt_pkg::REQ_W-1:0]      in_req_type,
	input  logic [spgt_pkg::ID_W-1:0]       in_group_id,
	input  logic [spgt_pkg::ADDR_W-1:0]     in_phys_addr,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [spgt_pkg::STS_W-1:0]      out_status,
	output logic                            out_is_member,
	output logic                            out_was_duplicate,
	output logic [spgt_pkg::COUNT_W-1:0]    out_proc_count,
	input  spgt_pkg::dp_cmd_t               cmd,
	output spgt_pkg::dp_sts_t               sts
);

	localparam int SW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int IW    = $clog2(PAGES_PER_GROUP);
	localparam int FW    = $clog2(PAGES_PER_GROUP + 1);
	localparam int PDEPTH = GROUPS << IW;
	localparam logic [FW-1:0] FILL_MAX = FW'(PAGES_PER_GROUP);

	function automatic logic [SW-1:0] first_set(input logic [GROUPS-1:0] v);
		logic [SW-1:0] r;
		r = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (v[g]) begin
				r = SW'(g);
			end
		end
		return r;
	endfunction

	// Captured request.
	logic [spgt_pkg::REQ_W-1:0]  req_q;
	logic [spgt_pkg::ID_W-1:0]   id_q;
	logic [spgt_pkg::ADDR_W-1:0] addr_q;

	// Slot registers, compared in parallel.
	logic [GROUPS-1:0]           used_q;
	logic [spgt_pkg::ID_W-1:0]   group_q [GROUPS];
	logic [GROUPS-1:0]           match_q;
	logic [GROUPS-1:0]           free_q;

	logic [SW-1:0]               slot_q;
	logic                        found_q;

	// Per slot memories, read at the selected slot.
	logic [spgt_pkg::COUNT_W-1:0] count_mem [GROUPS];
	logic [FW-1:0]                fill_mem  [GROUPS];
	logic [spgt_pkg::COUNT_W-1:0] cnt_q;
	logic [FW-1:0]                fill_q;

	// Page list memory and scan unit.
	logic [spgt_pkg::ADDR_W-1:0] page_mem [PDEPTH];
	logic [spgt_pkg::ADDR_W-1:0] page_rd_q;
	logic [FW-1:0]               idx_q;
	logic                        rd_v_q;
	logic                        page_hit_q;
	logic                        page_re;
	logic                        match_now;

	// Result register.
	logic                         out_valid_q;
	logic [spgt_pkg::STS_W-1:0]   status_q;
	logic                         member_q;
	logic                         dup_q;
	logic [spgt_pkg::COUNT_W-1:0] count_q;

	// Commit decision.
	logic                         is_create;
	logic                         id_none;
	logic                         addr_zero;
	logic [spgt_pkg::STS_W-1:0]   res_status;
	logic                         res_member;
	logic                         res_dup;
	logic [spgt_pkg::COUNT_W-1:0] res_count;
	logic                         cnt_we;
	logic [spgt_pkg::COUNT_W-1:0] cnt_wd;
	logic                         fill_we;
	logic [FW-1:0]                fill_wd;
	logic                         page_we;
	logic                         slot_claim;

	assign is_create = (req_q == spgt_pkg::REQ_CREATE);
	assign id_none   = (id_q == spgt_pkg::NO_GROUP);
	assign addr_zero = (addr_q == '0);

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= in_req_type;
			id_q   <= in_group_id;
			addr_q <= in_phys_addr;
		end
	end

	// Parallel compare over all slots, then priority selection.
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			for (int g = 0; g < GROUPS; g++) begin
				match_q[g] <= used_q[g] && (group_q[g] == id_q);
				free_q[g]  <= !used_q[g];
			end
		end
		if (cmd.select) begin
			slot_q  <= is_create ? first_set(free_q) : first_set(match_q);
			found_q <= is_create ? (|free_q) : (|match_q);
		end
	end

	// Slot valid bits and ids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (slot_claim) begin
			used_q[slot_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_claim) begin
			group_q[slot_q] <= id_q;
		end
	end

	// Count and fill memories.
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem[slot_q] <= cnt_wd;
		end
		if (fill_we) begin
			fill_mem[slot_q] <= fill_wd;
		end
		if (cmd.fetch) begin
			cnt_q  <= count_mem[slot_q];
			fill_q <= fill_mem[slot_q];
		end
	end

	// Page list scan: one read issued per cycle, compared the cycle after.
	assign page_re   = cmd.scan && (idx_q != fill_q);
	assign match_now = rd_v_q && (page_rd_q == addr_q);

	always_ff @(posedge clk) begin
		if (page_we) begin
			page_mem[{slot_q, fill_q[IW-1:0]}] <= addr_q;
		end
		if (page_re) begin
			page_rd_q <= page_mem[{slot_q, idx_q[IW-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			idx_q      <= '0;
			rd_v_q     <= 1'b0;
			page_hit_q <= 1'b0;
		end else if (cmd.scan) begin
			rd_v_q <= page_re;
			if (page_re) begin
				idx_q <= idx_q + FW'(1);
			end
			if (sts.scan_done) begin
				page_hit_q <= match_now;
			end
		end
	end

	assign sts.need_scan = (req_q == spgt_pkg::REQ_ADD || req_q == spgt_pkg::REQ_QUERY)
		&& !id_none && found_q && !addr_zero;
	assign sts.scan_done = match_now || (idx_q == fill_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	// Outcome of the request and the table updates it makes.
	always_comb begin
		res_status = spgt_pkg::ST_OK;
		res_member = 1'b0;
		res_dup    = 1'b0;
		res_count  = '0;
		cnt_we     = 1'b0;
		cnt_wd     = '0;
		fill_we    = 1'b0;
		fill_wd    = '0;
		page_we    = 1'b0;
		slot_claim = 1'b0;
		if (req_q > spgt_pkg::REQ_READ) begin
			res_status = spgt_pkg::ST_OK;
		end else if (id_none) begin
			res_status = spgt_pkg::ST_NOGROUP;
		end else if (is_create) begin
			if (!found_q) begin
				res_status = spgt_pkg::ST_FULL;
			end else begin
				slot_claim = cmd.commit;
				cnt_we     = cmd.commit;
				fill_we    = cmd.commit;
			end
		end else if (!found_q) begin
			res_status = spgt_pkg::ST_NOTFOUND;
		end else begin
			res_count = cnt_q;
			case (req_q)
				spgt_pkg::REQ_ADD: begin
					if (!addr_zero) begin
						if (page_hit_q) begin
							res_dup = 1'b1;
						end else if (fill_q >= FILL_MAX) begin
							res_status = spgt_pkg::ST_FULL;
						end else begin
							page_we = cmd.commit;
							fill_we = cmd.commit;
							fill_wd = fill_q + FW'(1);
						end
					end
				end
				spgt_pkg::REQ_QUERY: begin
					res_member = !addr_zero && page_hit_q;
				end
				spgt_pkg::REQ_INC: begin
					if (cnt_q >= spgt_pkg::COUNT_LIMIT) begin
						res_status = spgt_pkg::ST_LIMIT;
					end else begin
						res_count = cnt_q + 7'd1;
						cnt_we    = cmd.commit;
						cnt_wd    = res_count;
					end
				end
				spgt_pkg::REQ_DEC: begin
					if (cnt_q == '0) begin
						res_status = spgt_pkg::ST_LIMIT;
					end else begin
						res_count = cnt_q - 7'd1;
						cnt_we    = cmd.commit;
						cnt_wd    = res_count;
					end
				end
				default: begin
					res_count = cnt_q;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= res_status;
			member_q <= res_member;
			dup_q    <= res_dup;
			count_q  <= res_count;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_status        = status_q;
	assign out_is_member     = member_q;
	assign out_was_duplicate = dup_q;
	assign out_proc_count    = count_q;

endmodule

// ----- design/shared_page_group_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared page group table
// Table of copy-on-write sharing groups with per-group page lists.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req channel (valid/ready) with a request type,
// a group id and a page address; each request gives exactly one result on the
// rsp channel (valid/ready) with a status, membership and duplicate flags and
// the group's process count.
// A request is taken only when the block is idle. Lookup compares the id
// against all slots at once, then the first match (or first free slot for a
// create) is picked and its count and fill are read from small memories.
// Create, count and no-group requests skip the scan and commit their result
// after the fetch; the block then returns to idle to take the next request.
// Add and query requests for a known group with a non-zero address scan the
// group's page list one entry per cycle from a single-port memory, stopping at
// the first hit; the scan covers at most the pages listed in the group, itself
// at most PAGES_PER_GROUP, and a hit ends it early. The scan sets the
// throughput of page requests.
// Reset clears the slot valid bits, so the table starts empty at once; the
// page list memory needs no clearing, as only listed entries are ever read.
// If the receiver stalls, the result waits in the output register while the
// next request is accepted and processed; that request's result is held back
// until the earlier one has been taken.
// ----------------------------------------------------------------------------
module shared_page_group_table #(
	parameter int GROUPS          = spgt_pkg::DEF_GROUPS,
	parameter int PAGES_PER_GROUP = spgt_pkg::DEF_PAGES_PER_GROUP
) (
	input logic       clk,
	input logic       arst_n,
	spgt_req_if.sink  req,
	spgt_rsp_if.source rsp
);

	spgt_pkg::dp_cmd_t cmd;
	spgt_pkg::dp_sts_t sts;

	// The controller sequences each request; the datapath holds all storage.
	spgt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The group id is taken as its raw 16-bit pattern.
	spgt_dp #(
		.GROUPS          (GROUPS),
		.PAGES_PER_GROUP (PAGES_PER_GROUP)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_req_type       (req.req_type),
		.in_group_id       (16'(unsigned'(req.group_id))),
		.in_phys_addr      (req.phys_addr),
		.out_ready         (rsp.ready),
		.out_valid         (rsp.valid),
		.out_status        (rsp.status),
		.out_is_member     (rsp.is_member),
		.out_was_duplicate (rsp.was_duplicate),
		.out_proc_count    (rsp.proc_count),
		.cmd               (cmd),
		.sts               (sts)
	);

endmodule
